### hw/rtl/ddo_pkg.sv
// shared types, constants and the cordic arctangent table for the odometry block
// no dependencies; used by ddo_ctrl, ddo_datapath and diff_drive_odometry_core
package ddo_pkg;

  localparam int CFG_IDX_W  = 1;
  localparam int ATAN_IDX_W = 5;
  localparam int MUL_OP_W   = 4;

  typedef enum logic [0:0] {
    OP_SAMPLE = 1'b0,
    OP_LOAD   = 1'b1
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIST_PER_COUNT = 1'b0,
    CFG_TURN_PER_COUNT = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_ABS,
    ST_CORDIC,
    ST_TRIG,
    ST_MUL,
    ST_COMMIT,
    ST_EMIT
  } state_t;

  // multiply schedule, issued in this order
  typedef enum logic [MUL_OP_W-1:0] {
    MUL_TRAVEL,
    MUL_DH_LO,
    MUL_DH_HI,
    MUL_LIN,
    MUL_ANG_LO,
    MUL_ANG_HI,
    MUL_X_HI,
    MUL_X_LO,
    MUL_Y_HI,
    MUL_Y_LO
  } mul_op_t;

  localparam logic [MUL_OP_W-1:0] NUM_MUL_OPS = 4'd10;

  typedef struct packed {
    logic                  capture;
    logic                  prep;
    logic                  absd;
    logic                  cordic_step;
    logic [ATAN_IDX_W-1:0] cordic_idx;
    logic                  trig;
    logic                  mul_en;
    mul_op_t               mul_op;
    logic                  acc_en;
    mul_op_t               acc_op;
    logic                  commit;
    logic                  out_load;
  } ctl_cmd_t;

  localparam logic [31:0]        DIST_RESET   = 32'd2248817;
  localparam logic [39:0]        TURN_RESET   = 40'd763549741;
  localparam logic signed [32:0] CORDIC_START = 33'sd652032874;

  // atan(2^-i) in 2^-32 turn units
  function automatic logic [29:0] atan_turn(input logic [ATAN_IDX_W-1:0] idx);
    logic [29:0] v;
    case (idx)
      5'd0:    v = 30'd536870912;
      5'd1:    v = 30'd316933406;
      5'd2:    v = 30'd167458907;
      5'd3:    v = 30'd85004756;
      5'd4:    v = 30'd42667331;
      5'd5:    v = 30'd21354465;
      5'd6:    v = 30'd10679838;
      5'd7:    v = 30'd5340245;
      5'd8:    v = 30'd2670163;
      5'd9:    v = 30'd1335087;
      5'd10:   v = 30'd667544;
      5'd11:   v = 30'd333772;
      5'd12:   v = 30'd166886;
      5'd13:   v = 30'd83443;
      5'd14:   v = 30'd41722;
      5'd15:   v = 30'd20861;
      5'd16:   v = 30'd10430;
      5'd17:   v = 30'd5215;
      5'd18:   v = 30'd2608;
      5'd19:   v = 30'd1304;
      5'd20:   v = 30'd652;
      5'd21:   v = 30'd326;
      5'd22:   v = 30'd163;
      5'd23:   v = 30'd81;
      5'd24:   v = 30'd41;
      5'd25:   v = 30'd20;
      5'd26:   v = 30'd10;
      5'd27:   v = 30'd5;
      5'd28:   v = 30'd3;
      5'd29:   v = 30'd1;
      5'd30:   v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

### hw/rtl/ddo_ctrl.sv
// sequencer for the odometry datapath: handshakes, cordic step count, multiply schedule
// depends on ddo_pkg
module ddo_ctrl #(
  parameter int CORDIC_STEPS = 24
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_opcode,
  output logic              in_stall,
  input  logic              out_stall,
  output logic              out_valid,
  output ddo_pkg::ctl_cmd_t cmd
);
  import ddo_pkg::*;

  localparam int STEP_W = $clog2(CORDIC_STEPS);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

  state_t                state_r, state_nxt;
  logic [STEP_W-1:0]     step_cnt_r, step_cnt_nxt;
  logic [MUL_OP_W-1:0]   op_cnt_r, op_cnt_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  accept;
  logic                  out_free;

  assign accept   = in_valid && (state_r == ST_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = (in_opcode == OP_LOAD) ? ST_COMMIT : ST_PREP;
        end
      end
      ST_PREP:   state_nxt = ST_ABS;
      ST_ABS:    state_nxt = ST_CORDIC;
      ST_CORDIC: begin
        if (step_cnt_r == LAST_STEP) begin
          state_nxt = ST_TRIG;
        end
      end
      ST_TRIG:   state_nxt = ST_MUL;
      ST_MUL: begin
        if (op_cnt_r == NUM_MUL_OPS) begin
          state_nxt = ST_COMMIT;
        end
      end
      ST_COMMIT: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd             = '0;
    cmd.mul_op      = MUL_TRAVEL;
    cmd.acc_op      = MUL_TRAVEL;
    cmd.capture     = accept;
    cmd.cordic_idx  = ATAN_IDX_W'(step_cnt_r);
    step_cnt_nxt    = '0;
    op_cnt_nxt      = '0;
    unique case (state_r)
      ST_IDLE:   ;
      ST_PREP:   cmd.prep = 1'b1;
      ST_ABS:    cmd.absd = 1'b1;
      ST_CORDIC: begin
        cmd.cordic_step = 1'b1;
        step_cnt_nxt    = step_cnt_r + 1'b1;
      end
      ST_TRIG:   cmd.trig = 1'b1;
      ST_MUL: begin
        // issue op n while folding in the product of op n-1
        cmd.mul_en = (op_cnt_r < NUM_MUL_OPS);
        cmd.mul_op = mul_op_t'(op_cnt_r);
        cmd.acc_en = (op_cnt_r != '0);
        cmd.acc_op = mul_op_t'(op_cnt_r - 1'b1);
        op_cnt_nxt = op_cnt_r + 1'b1;
      end
      ST_COMMIT: cmd.commit = 1'b1;
      ST_EMIT:   cmd.out_load = out_free;
      default:   ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_cnt_r  <= '0;
      op_cnt_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_cnt_r  <= step_cnt_nxt;
      op_cnt_r    <= op_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### hw/rtl/ddo_datapath.sv
// odometry datapath: pose state, scale registers, cordic rotator, shared 33x33 multiplier
// and the output register; depends on ddo_pkg, driven by ddo_ctrl commands
module ddo_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  ddo_pkg::ctl_cmd_t                 cmd,
  input  logic                              cfg_we,
  input  logic [ddo_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [39:0]                       cfg_data,
  input  logic                              in_opcode,
  input  logic signed [31:0]                in_left_count,
  input  logic signed [31:0]                in_right_count,
  input  logic signed [15:0]                in_left_rate,
  input  logic signed [15:0]                in_right_rate,
  input  logic signed [31:0]                in_est_x,
  input  logic signed [31:0]                in_est_y,
  input  logic [31:0]                       in_est_heading,
  output logic signed [31:0]                pos_x,
  output logic signed [31:0]                pos_y,
  output logic [31:0]                       heading,
  output logic signed [31:0]                lin_vel,
  output logic signed [47:0]                ang_vel
);
  import ddo_pkg::*;

  // configuration and architectural state
  logic [31:0] dpc_r;
  logic [39:0] tpc_r;
  logic [47:0] acc_x_r, acc_x_nxt;
  logic [47:0] acc_y_r, acc_y_nxt;
  logic [31:0] acc_heading_r, acc_heading_nxt;
  logic [31:0] last_left_r, last_right_r;

  // captured word
  logic        opcode_r;
  logic [31:0] est_x_r, est_y_r, est_heading_r;
  logic [31:0] dl_r, dr_r;
  logic signed [16:0] vs_r, vd_r;

  // deltas and magnitudes
  logic signed [32:0] sum_r, diff_r;
  logic [32:0] sum_abs_r, diff_abs_r;
  logic        sum_neg_r, diff_neg_r;
  logic [16:0] vs_abs_r, vd_abs_r;
  logic        vs_neg_r, vd_neg_r;

  // cordic
  logic signed [32:0] cx_r, cy_r, cz_r;
  logic        flip_r;
  logic        h_flip;
  logic signed [32:0] cx_sh, cy_sh, atan_v;
  logic [31:0] cos_abs_r, sin_abs_r;
  logic        cos_neg_r, sin_neg_r;

  // multiplier and partial results
  logic [32:0] mul_a, mul_b;
  logic [65:0] mul_p;
  logic [65:0] prod_r;
  logic [62:0] travel_r;
  logic [39:0] dh_acc_r;
  logic [31:0] lin_mag_r;
  logic [56:0] ang_mag_r;
  logic [47:0] xstep_r, ystep_r;
  logic [31:0] lin_r, lin_nxt;
  logic [47:0] ang_r, ang_nxt;
  logic [48:0] ang_m;
  logic [31:0] dh;

  // output register
  logic [31:0] pos_x_r, pos_y_r, heading_r, lin_vel_r;
  logic [47:0] ang_vel_r;

  assign h_flip = acc_heading_r[31] ^ acc_heading_r[30];
  assign cx_sh  = cx_r >>> cmd.cordic_idx;
  assign cy_sh  = cy_r >>> cmd.cordic_idx;
  assign atan_v = $signed({3'b000, atan_turn(cmd.cordic_idx)});

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.mul_op)
      MUL_TRAVEL: begin
        mul_a = sum_abs_r;
        mul_b = {1'b0, dpc_r};
      end
      MUL_DH_LO: begin
        mul_a = diff_abs_r;
        mul_b = {1'b0, tpc_r[31:0]};
      end
      MUL_DH_HI: begin
        mul_a = diff_abs_r;
        mul_b = {25'b0, tpc_r[39:32]};
      end
      MUL_LIN: begin
        mul_a = {16'b0, vs_abs_r};
        mul_b = {1'b0, dpc_r};
      end
      MUL_ANG_LO: begin
        mul_a = {16'b0, vd_abs_r};
        mul_b = {1'b0, tpc_r[31:0]};
      end
      MUL_ANG_HI: begin
        mul_a = {16'b0, vd_abs_r};
        mul_b = {25'b0, tpc_r[39:32]};
      end
      MUL_X_HI: begin
        mul_a = {2'b0, travel_r[62:32]};
        mul_b = {1'b0, cos_abs_r};
      end
      MUL_X_LO: begin
        mul_a = {1'b0, travel_r[31:0]};
        mul_b = {1'b0, cos_abs_r};
      end
      MUL_Y_HI: begin
        mul_a = {2'b0, travel_r[62:32]};
        mul_b = {1'b0, sin_abs_r};
      end
      MUL_Y_LO: begin
        mul_a = {1'b0, travel_r[31:0]};
        mul_b = {1'b0, sin_abs_r};
      end
      default: ;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // pose update, velocity saturation
  assign dh    = dh_acc_r[39:8];
  assign ang_m = ang_mag_r[56:8];

  always_comb begin
    acc_x_nxt       = acc_x_r;
    acc_y_nxt       = acc_y_r;
    acc_heading_nxt = acc_heading_r;
    if (opcode_r == OP_LOAD) begin
      acc_x_nxt       = {est_x_r, 16'b0};
      acc_y_nxt       = {est_y_r, 16'b0};
      acc_heading_nxt = est_heading_r;
    end else begin
      acc_x_nxt = (sum_neg_r ^ cos_neg_r) ? acc_x_r - xstep_r : acc_x_r + xstep_r;
      acc_y_nxt = (sum_neg_r ^ sin_neg_r) ? acc_y_r - ystep_r : acc_y_r + ystep_r;
      acc_heading_nxt = diff_neg_r ? acc_heading_r - dh : acc_heading_r + dh;
    end
  end

  always_comb begin
    lin_nxt = '0;
    ang_nxt = '0;
    if (opcode_r == OP_SAMPLE) begin
      if (vs_neg_r) begin
        lin_nxt = lin_mag_r[31] ? 32'h8000_0000 : 32'(-lin_mag_r);
      end else begin
        lin_nxt = lin_mag_r[31] ? 32'h7FFF_FFFF : lin_mag_r;
      end
      if (vd_neg_r) begin
        ang_nxt = (|ang_m[48:47]) ? 48'h8000_0000_0000 : 48'(-ang_m[47:0]);
      end else begin
        ang_nxt = (|ang_m[48:47]) ? 48'h7FFF_FFFF_FFFF : ang_m[47:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dpc_r         <= DIST_RESET;
      tpc_r         <= TURN_RESET;
      acc_x_r       <= '0;
      acc_y_r       <= '0;
      acc_heading_r <= '0;
      last_left_r   <= '0;
      last_right_r  <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_DIST_PER_COUNT: dpc_r <= cfg_data[31:0];
          CFG_TURN_PER_COUNT: tpc_r <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.capture && (in_opcode == OP_SAMPLE)) begin
        last_left_r  <= in_left_count;
        last_right_r <= in_right_count;
      end
      if (cmd.commit) begin
        acc_x_r       <= acc_x_nxt;
        acc_y_r       <= acc_y_nxt;
        acc_heading_r <= acc_heading_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      opcode_r      <= in_opcode;
      est_x_r       <= in_est_x;
      est_y_r       <= in_est_y;
      est_heading_r <= in_est_heading;
      dl_r          <= in_left_count - last_left_r;
      dr_r          <= in_right_count - last_right_r;
      vs_r          <= {in_left_rate[15], in_left_rate} + {in_right_rate[15], in_right_rate};
      vd_r          <= {in_left_rate[15], in_left_rate} - {in_right_rate[15], in_right_rate};
    end

    if (cmd.prep) begin
      sum_r    <= $signed({dl_r[31], dl_r}) + $signed({dr_r[31], dr_r});
      diff_r   <= $signed({dl_r[31], dl_r}) - $signed({dr_r[31], dr_r});
      vs_neg_r <= vs_r[16];
      vd_neg_r <= vd_r[16];
      vs_abs_r <= vs_r[16] ? 17'(-vs_r) : vs_r;
      vd_abs_r <= vd_r[16] ? 17'(-vd_r) : vd_r;
      // fold the heading into the right half plane
      flip_r   <= h_flip;
      cx_r     <= CORDIC_START;
      cy_r     <= '0;
      cz_r     <= $signed({acc_heading_r[31] ^ h_flip, acc_heading_r[31] ^ h_flip,
                           acc_heading_r[30:0]});
    end

    if (cmd.absd) begin
      sum_neg_r  <= sum_r[32];
      diff_neg_r <= diff_r[32];
      sum_abs_r  <= sum_r[32] ? 33'(-sum_r) : sum_r;
      diff_abs_r <= diff_r[32] ? 33'(-diff_r) : diff_r;
    end

    if (cmd.cordic_step) begin
      if (!cz_r[32]) begin
        cx_r <= cx_r - cy_sh;
        cy_r <= cy_r + cx_sh;
        cz_r <= cz_r - atan_v;
      end else begin
        cx_r <= cx_r + cy_sh;
        cy_r <= cy_r - cx_sh;
        cz_r <= cz_r + atan_v;
      end
    end

    if (cmd.trig) begin
      cos_abs_r <= cx_r[32] ? 32'(-cx_r) : cx_r[31:0];
      sin_abs_r <= cy_r[32] ? 32'(-cy_r) : cy_r[31:0];
      cos_neg_r <= flip_r ? (!cx_r[32] && (cx_r != '0)) : cx_r[32];
      sin_neg_r <= flip_r ? (!cy_r[32] && (cy_r != '0)) : cy_r[32];
    end

    if (cmd.mul_en) begin
      prod_r <= mul_p;
    end

    if (cmd.acc_en) begin
      case (cmd.acc_op)
        MUL_TRAVEL: travel_r  <= prod_r[63:1];
        MUL_DH_LO:  dh_acc_r  <= prod_r[39:0];
        MUL_DH_HI:  dh_acc_r  <= dh_acc_r + {prod_r[7:0], 32'b0};
        MUL_LIN:    lin_mag_r <= prod_r[48:17];
        MUL_ANG_LO: ang_mag_r <= prod_r[56:0];
        MUL_ANG_HI: ang_mag_r <= ang_mag_r + {prod_r[24:0], 32'b0};
        MUL_X_HI:   xstep_r   <= {prod_r[45:0], 2'b00};
        MUL_X_LO:   xstep_r   <= xstep_r + {14'b0, prod_r[63:30]};
        MUL_Y_HI:   ystep_r   <= {prod_r[45:0], 2'b00};
        MUL_Y_LO:   ystep_r   <= ystep_r + {14'b0, prod_r[63:30]};
        default: ;
      endcase
    end

    if (cmd.commit) begin
      lin_r <= lin_nxt;
      ang_r <= ang_nxt;
    end

    if (cmd.out_load) begin
      pos_x_r   <= acc_x_r[47:16];
      pos_y_r   <= acc_y_r[47:16];
      heading_r <= acc_heading_r;
      lin_vel_r <= lin_r;
      ang_vel_r <= ang_r;
    end
  end

  assign pos_x   = $signed(pos_x_r);
  assign pos_y   = $signed(pos_y_r);
  assign heading = heading_r;
  assign lin_vel = $signed(lin_vel_r);
  assign ang_vel = $signed(ang_vel_r);

endmodule

### hw/rtl/diff_drive_odometry_core.sv
// sample word: after accept, the iterative cordic (one micro-rotation per cycle) and ten
// passes through one shared 33x33 multiplier run before the pose commit and the result;
// a load word goes straight to the commit. one word is worked at a time; the
// next is accepted once the previous result sits in the output register.
// synchronous active-low reset zeroes pose and last counts, drops out_valid and returns
// the scale registers to their defaults
module diff_drive_odometry_core #(
  parameter int CORDIC_STEPS = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_opcode,
  input  logic signed [31:0]            in_left_count,
  input  logic signed [31:0]            in_right_count,
  input  logic signed [15:0]            in_left_rate,
  input  logic signed [15:0]            in_right_rate,
  input  logic signed [31:0]            in_est_x,
  input  logic signed [31:0]            in_est_y,
  input  logic [31:0]                   in_est_heading,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [31:0]            out_pos_x,
  output logic signed [31:0]            out_pos_y,
  output logic [31:0]                   out_heading,
  output logic signed [31:0]            out_lin_vel,
  output logic signed [47:0]            out_ang_vel,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ddo_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [39:0]                   cfg_data
);
  import ddo_pkg::*;

  ctl_cmd_t cmd;
  logic     cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  ddo_ctrl #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_opcode),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  ddo_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_opcode      (in_opcode),
    .in_left_count  (in_left_count),
    .in_right_count (in_right_count),
    .in_left_rate   (in_left_rate),
    .in_right_rate  (in_right_rate),
    .in_est_x       (in_est_x),
    .in_est_y       (in_est_y),
    .in_est_heading (in_est_heading),
    .pos_x          (out_pos_x),
    .pos_y          (out_pos_y),
    .heading        (out_heading),
    .lin_vel        (out_lin_vel),
    .ang_vel        (out_ang_vel)
  );

  // a word in flight blocks the input until its result is handed off
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while a word is in flight");

  // a held result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid || !out_stall))
    else $error("output register loaded while its word is still held");

  // a new result appears only right after a pose commit
  a_result_after_commit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(cmd.commit, 2))
    else $error("result raised without a preceding commit");

endmodule

### bench/diff_drive_odometry_core_tb.sv
// testbench for diff_drive_odometry_core: directed and random encoder and load words,
// each result checked against a pose tracker kept in the bench
// depends on ddo_pkg and diff_drive_odometry_core
`timescale 1ns / 100ps

module diff_drive_odometry_core_tb;
  import ddo_pkg::*;

  localparam int CORDIC_STEPS = 24;
  localparam longint CORDIC_X0 = 652032874;

  typedef struct {
    opcode_t            op;
    logic signed [31:0] left_count;
    logic signed [31:0] right_count;
    logic signed [15:0] left_rate;
    logic signed [15:0] right_rate;
    logic signed [31:0] est_x;
    logic signed [31:0] est_y;
    logic [31:0]        est_heading;
  } odo_word_t;

  typedef struct {
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] heading;
    logic [31:0] lin_vel;
    logic [47:0] ang_vel;
  } pose_word_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_opcode = 1'b0;
  logic signed [31:0] in_left_count = '0;
  logic signed [31:0] in_right_count = '0;
  logic signed [15:0] in_left_rate = '0;
  logic signed [15:0] in_right_rate = '0;
  logic signed [31:0] in_est_x = '0;
  logic signed [31:0] in_est_y = '0;
  logic [31:0]        in_est_heading = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] out_pos_x;
  logic signed [31:0] out_pos_y;
  logic [31:0]        out_heading;
  logic signed [31:0] out_lin_vel;
  logic signed [47:0] out_ang_vel;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  cfg_reg_t           cfg_index = CFG_DIST_PER_COUNT;
  logic [39:0]        cfg_data = '0;

  // pose tracker and scale copies
  bit [47:0] trk_x = '0;
  bit [47:0] trk_y = '0;
  bit [31:0] trk_heading = '0;
  bit [31:0] prev_left = '0;
  bit [31:0] prev_right = '0;
  bit [31:0] dist_scale = 32'd2248817;
  bit [39:0] turn_scale = 40'd763549741;

  // atan(2^-i) in 2^-32 turn units
  longint atan_lut [32] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10,
    5, 3, 1, 1, 0
  };

  pose_word_t  pose_q [$];
  pose_word_t  want;
  int unsigned mismatch_count = 0;
  int unsigned tx_idle_pct = 10;
  int unsigned rx_idle_pct = 85;
  logic signed [31:0] cur_left = '0;
  logic signed [31:0] cur_right = '0;

  diff_drive_odometry_core #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_opcode      (in_opcode),
    .in_left_count  (in_left_count),
    .in_right_count (in_right_count),
    .in_left_rate   (in_left_rate),
    .in_right_rate  (in_right_rate),
    .in_est_x       (in_est_x),
    .in_est_y       (in_est_y),
    .in_est_heading (in_est_heading),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_pos_x      (out_pos_x),
    .out_pos_y      (out_pos_y),
    .out_heading    (out_heading),
    .out_lin_vel    (out_lin_vel),
    .out_ang_vel    (out_ang_vel),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("diff_drive_odometry_core_tb NOT OK");
    $finish;
  end

  function automatic void cordic_sincos(input bit [31:0] ang, output longint cs,
                                        output longint sn);
    bit [31:0] h;
    bit [31:0] probe;
    bit        flip;
    longint    x;
    longint    y;
    longint    z;
    longint    nx;
    h = ang;
    probe = h + 32'h4000_0000;
    // rotate the left half plane by half a turn so the cordic converges
    flip = probe[31];
    if (flip) h = h - 32'h8000_0000;
    z = int'(h);
    x = CORDIC_X0;
    y = 0;
    for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z = z - atan_lut[i];
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z = z + atan_lut[i];
      end
      x = nx;
    end
    cs = flip ? -x : x;
    sn = flip ? -y : y;
  endfunction

  function automatic bit [47:0] step_axis(input bit [47:0] acc, input bit [63:0] travel,
                                          input bit tneg, input longint f);
    bit        fneg;
    bit [63:0] k;
    bit [63:0] hi;
    bit [63:0] lo;
    bit [63:0] mag;
    fneg = (f < 0);
    k = fneg ? -f : f;
    hi = travel >> 32;
    lo = {32'h0, travel[31:0]};
    // (travel * k) >> 30, wrapping at 64 bits
    mag = ((hi * k) << 2) + ((lo * k) >> 30);
    if (tneg != fneg) mag = -mag;
    return acc + mag[47:0];
  endfunction

  function automatic pose_word_t advance_pose(input odo_word_t w);
    pose_word_t r;
    bit [31:0]  du;
    bit [31:0]  dv;
    bit [31:0]  dh;
    longint     dl;
    longint     dr;
    longint     wsum;
    longint     wdiff;
    longint     vs;
    longint     vd;
    longint     cs;
    longint     sn;
    bit [63:0]  mag;
    bit [63:0]  travel;
    bit [63:0]  prod;
    bit [63:0]  m;
    r.lin_vel = '0;
    r.ang_vel = '0;
    if (w.op == OP_LOAD) begin
      trk_x = {w.est_x, 16'h0000};
      trk_y = {w.est_y, 16'h0000};
      trk_heading = w.est_heading;
    end else begin
      du = w.left_count - prev_left;
      dv = w.right_count - prev_right;
      dl = int'(du);
      dr = int'(dv);
      prev_left = w.left_count;
      prev_right = w.right_count;
      wsum = dl + dr;
      wdiff = dl - dr;
      mag = (wsum < 0) ? -wsum : wsum;
      travel = (mag * {32'h0, dist_scale}) >> 1;
      // position moves along the heading held before this word
      cordic_sincos(trk_heading, cs, sn);
      trk_x = step_axis(trk_x, travel, wsum < 0, cs);
      trk_y = step_axis(trk_y, travel, wsum < 0, sn);
      mag = (wdiff < 0) ? -wdiff : wdiff;
      prod = mag * {24'h0, turn_scale};
      dh = prod[39:8];
      if (wdiff < 0) dh = -dh;
      trk_heading = trk_heading + dh;

      vs = longint'(w.left_rate) + longint'(w.right_rate);
      vd = longint'(w.left_rate) - longint'(w.right_rate);
      mag = (vs < 0) ? -vs : vs;
      m = (mag * {32'h0, dist_scale}) >> 17;
      if (vs < 0) begin
        if (m > 64'h8000_0000) m = 64'h8000_0000;
        m = -m;
      end else if (m > 64'h7FFF_FFFF) begin
        m = 64'h7FFF_FFFF;
      end
      r.lin_vel = m[31:0];
      mag = (vd < 0) ? -vd : vd;
      m = (mag * {24'h0, turn_scale}) >> 8;
      if (vd < 0) begin
        if (m > 64'h8000_0000_0000) m = 64'h8000_0000_0000;
        m = -m;
      end else if (m > 64'h7FFF_FFFF_FFFF) begin
        m = 64'h7FFF_FFFF_FFFF;
      end
      r.ang_vel = m[47:0];
    end
    r.pos_x = trk_x[47:16];
    r.pos_y = trk_y[47:16];
    r.heading = trk_heading;
    return r;
  endfunction

  function automatic odo_word_t make_sample(input logic signed [31:0] l,
                                            input logic signed [31:0] r,
                                            input logic signed [15:0] lr,
                                            input logic signed [15:0] rr);
    odo_word_t w;
    w.op = OP_SAMPLE;
    w.left_count = l;
    w.right_count = r;
    w.left_rate = lr;
    w.right_rate = rr;
    w.est_x = $urandom();
    w.est_y = $urandom();
    w.est_heading = $urandom();
    return w;
  endfunction

  function automatic odo_word_t make_load(input logic signed [31:0] x,
                                          input logic signed [31:0] y,
                                          input logic [31:0] h);
    odo_word_t w;
    w = make_sample($urandom(), $urandom(), 16'($urandom()), 16'($urandom()));
    w.op = OP_LOAD;
    w.est_x = x;
    w.est_y = y;
    w.est_heading = h;
    return w;
  endfunction

  task automatic send_word(input odo_word_t w);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_opcode      <= w.op;
    in_left_count  <= w.left_count;
    in_right_count <= w.right_count;
    in_left_rate   <= w.left_rate;
    in_right_rate  <= w.right_rate;
    in_est_x       <= w.est_x;
    in_est_y       <= w.est_y;
    in_est_heading <= w.est_heading;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pose_q.push_back(advance_pose(w));
    if (w.op == OP_SAMPLE) begin
      cur_left = w.left_count;
      cur_right = w.right_count;
    end
  endtask

  task automatic finish_burst();
    in_valid <= 1'b0;
    while (pose_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_scale(input cfg_reg_t idx, input logic [39:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_DIST_PER_COUNT) dist_scale = val[31:0];
    else turn_scale = val;
  endtask

  task automatic set_scales(input logic [39:0] dist_word, input logic [39:0] turn_word);
    finish_burst();
    write_scale(CFG_DIST_PER_COUNT, dist_word);
    write_scale(CFG_TURN_PER_COUNT, turn_word);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_reset_pose();
    send_word(make_sample(0, 0, 0, 0));
  endtask

  task automatic test_rate_extremes();
    // counts held, so only the velocity outputs move
    send_word(make_sample(cur_left, cur_right, 16'sh7FFF, -16'sh8000));
    send_word(make_sample(cur_left, cur_right, -16'sh8000, 16'sh7FFF));
    send_word(make_sample(cur_left, cur_right, -16'sh8000, -16'sh8000));
    send_word(make_sample(cur_left, cur_right, 16'sh7FFF, 16'sh7FFF));
  endtask

  task automatic test_count_wrap();
    send_word(make_sample(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 16'($urandom()),
                          16'($urandom())));
    send_word(make_sample(32'h8000_0000, 32'h8000_0000, 16'($urandom()), 16'($urandom())));
    send_word(make_sample(32'h0000_0000, 32'h8000_0000, 16'($urandom()), 16'($urandom())));
    // both deltas at the most negative value
    send_word(make_sample(32'h8000_0000, 32'h0000_0000, 16'($urandom()), 16'($urandom())));
  endtask

  task automatic test_load_pose();
    logic [31:0] quad [3];
    quad = '{32'h4000_0000, 32'h8000_0000, 32'hC000_0000};
    send_word(make_load(32'sh7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF));
    foreach (quad[i]) begin
      send_word(make_load(0, 0, quad[i]));
      send_word(make_sample(cur_left + 1000, cur_right + 1000, 16'($urandom()),
                            16'($urandom())));
    end
    // forward travel across the positive edge of x and y
    send_word(make_load(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'h2000_0000));
    send_word(make_sample(cur_left + 200000, cur_right + 200000, 16'($urandom()),
                          16'($urandom())));
  endtask

  task automatic test_scale_extremes();
    set_scales('0, '0);
    send_word(make_sample(cur_left + 5000, cur_right - 3000, 16'sh7FFF, -16'sh8000));
    set_scales(40'hFF_FFFF_FFFF, 40'hFF_FFFF_FFFF);
    send_word(make_sample(cur_left + 32'h8000_0000, cur_right + 32'h8000_0000,
                          -16'sh8000, 16'sh7FFF));
    send_word(make_sample(cur_left + 12345, cur_right - 54321, 16'sh7FFF, -16'sh8000));
    set_scales(40'd2248817, 40'd763549741);
  endtask

  task automatic test_random_motion(input int unsigned n_words);
    odo_word_t   w;
    int unsigned pick;
    int          step_l;
    int          step_r;
    repeat (n_words) begin
      pick = $urandom_range(99);
      w = make_sample($urandom(), $urandom(), 16'($urandom()), 16'($urandom()));
      if (pick < 60) begin
        // smooth driving: small deltas, mild turning
        step_l = int'($urandom_range(4000)) - 2000;
        step_r = step_l + int'($urandom_range(240)) - 120;
        w.left_count = cur_left + step_l;
        w.right_count = cur_right + step_r;
        if ($urandom_range(3) != 0) begin
          w.left_rate = 16'(int'($urandom_range(3000)) - 1500);
          w.right_rate = 16'(int'($urandom_range(3000)) - 1500);
        end
      end else if (pick < 76) begin
        w = make_load($urandom(), $urandom(), $urandom());
        if ($urandom_range(1) != 0) begin
          w.est_x = w.est_x >>> 8;
          w.est_y = w.est_y >>> 8;
        end
      end else if (pick < 86) begin
        w.left_count = cur_left;
        w.right_count = cur_right;
      end
      // otherwise keep the wide random counts
      send_word(w);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pose_q.size() == 0) begin
        if (mismatch_count < 10)
          $display("%0t: unexpected word x=%h y=%h hdg=%h lin=%h ang=%h", $realtime,
                   out_pos_x, out_pos_y, out_heading, out_lin_vel, out_ang_vel);
        mismatch_count++;
      end else begin
        want = pose_q.pop_front();
        if (want.pos_x !== out_pos_x || want.pos_y !== out_pos_y ||
            want.heading !== out_heading || want.lin_vel !== out_lin_vel ||
            want.ang_vel !== out_ang_vel) begin
          if (mismatch_count < 10) begin
            $display("%0t: pose mismatch", $realtime);
            $display("  pos_x   exp %h got %h", want.pos_x, out_pos_x);
            $display("  pos_y   exp %h got %h", want.pos_y, out_pos_y);
            $display("  heading exp %h got %h", want.heading, out_heading);
            $display("  lin_vel exp %h got %h", want.lin_vel, out_lin_vel);
            $display("  ang_vel exp %h got %h", want.ang_vel, out_ang_vel);
          end
          mismatch_count++;
        end
      end
    end
    out_stall <= ($urandom_range(99) < rx_idle_pct);
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_pose();
    test_rate_extremes();
    test_count_wrap();
    test_load_pose();
    test_scale_extremes();

    test_random_motion(510);

    set_scales({8'hA5, 32'($urandom())}, {8'($urandom()), 32'($urandom())});
    tx_idle_pct = 85;
    rx_idle_pct = 10;
    test_random_motion(510);

    set_scales(40'($urandom_range(5000000, 100000)), 40'($urandom()));
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random_motion(510);

    finish_burst();
    repeat (60) @(posedge clk);
    if (mismatch_count == 0 && pose_q.size() == 0) begin
      $display("diff_drive_odometry_core_tb OK");
    end else begin
      $display("diff_drive_odometry_core_tb NOT OK");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/ddo_pkg.sv
hw/rtl/ddo_ctrl.sv
hw/rtl/ddo_datapath.sv
hw/rtl/diff_drive_odometry_core.sv
bench/diff_drive_odometry_core_tb.sv
